// ===== sv/scpd_pkg.sv =====
// Package for the serial command LED PWM dimmer: shared types and constants.
// Used by scpd_parser and serial_command_led_pwm_dimmer_core; no dependencies.

package scpd_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_PERIOD_TICKS = 3'd0;
   localparam logic [2:0] REG_LEVEL_OPEN   = 3'd1;
   localparam logic [2:0] REG_LEVEL_CLOSE  = 3'd2;
   localparam logic [2:0] REG_LEVEL_MID    = 3'd3;
   localparam logic [2:0] REG_LEVEL_HIGH   = 3'd4;

   // Register reset values
   localparam logic [3:0] PERIOD_RESET = 4'd10;
   localparam logic [3:0] OPEN_RESET   = 4'd3;
   localparam logic [3:0] CLOSE_RESET  = 4'd1;
   localparam logic [3:0] MID_RESET    = 4'd6;
   localparam logic [3:0] HIGH_RESET   = 4'd9;
   localparam logic [3:0] DUTY_RESET   = 4'd3;

   // Item kinds on the request channel
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_BYTE = 1'b1;

   // Characters the parser knows
   localparam logic [7:0] CHAR_O_UP = 8'h4F;
   localparam logic [7:0] CHAR_O_LO = 8'h6F;
   localparam logic [7:0] CHAR_S_UP = 8'h53;
   localparam logic [7:0] CHAR_S_LO = 8'h73;
   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_B_UP = 8'h42;
   localparam logic [7:0] CHAR_B_LO = 8'h62;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_N    = 8'h4E;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;

   // Duty levels picked by the command letters
   typedef struct packed {
      logic [3:0] open;
      logic [3:0] close;
      logic [3:0] mid;
      logic [3:0] high;
   } levels_type;

   // Duty write request from the parser
   typedef struct packed {
      logic       one;     // write channel ch
      logic       all;     // write every channel
      logic [2:0] ch;
      logic [3:0] level;
   } duty_cmd_type;

endpackage

// ===== sv/scpd_parser.sv =====
// Two-character serial command parser of the LED PWM dimmer.
// Depends on scpd_pkg; holds the parse mode and issues duty write requests.

module scpd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            rx_byte,
   input  scpd_pkg::levels_type  levels,
   output scpd_pkg::duty_cmd_type duty_cmd
);
   import scpd_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_OPEN,
      MODE_CLOSE,
      MODE_ALT,
      MODE_MID,
      MODE_HIGH
   } mode_type;

   mode_type mode_ff, mode_in;
   mode_type sel_mode;
   logic     is_digit, is_n, all_ok;
   logic [3:0] lvl;

   // Letter decode, then the write the selected mode allows
   always_comb begin
      is_digit = (rx_byte >= CHAR_ONE) && (rx_byte <= CHAR_EIGHT);
      is_n     = (rx_byte == CHAR_N);

      case (rx_byte)
         CHAR_O_UP, CHAR_O_LO: sel_mode = MODE_OPEN;
         CHAR_S_UP, CHAR_S_LO: sel_mode = MODE_CLOSE;
         CHAR_A_UP, CHAR_A_LO: sel_mode = MODE_ALT;
         CHAR_B_UP, CHAR_B_LO: sel_mode = MODE_MID;
         CHAR_C_UP, CHAR_C_LO: sel_mode = MODE_HIGH;
         default:              sel_mode = (is_digit || is_n) ? mode_ff : MODE_IDLE;
      endcase

      lvl    = 4'd0;
      all_ok = 1'b0;
      unique case (sel_mode)
         MODE_OPEN, MODE_ALT: begin
            lvl    = levels.open;
            all_ok = 1'b1;
         end
         MODE_CLOSE: begin
            lvl    = levels.close;
            all_ok = 1'b1;
         end
         MODE_MID:  lvl = levels.mid;
         MODE_HIGH: lvl = levels.high;
         default:   lvl = 4'd0;
      endcase

      duty_cmd.level = lvl;
      duty_cmd.ch    = 3'(rx_byte - CHAR_ONE);
      duty_cmd.one   = byte_valid && (sel_mode != MODE_IDLE) && is_digit;
      duty_cmd.all   = byte_valid && all_ok && is_n;

      mode_in = mode_ff;
      if (byte_valid) begin
         if (duty_cmd.one || duty_cmd.all) begin
            mode_in = MODE_IDLE;
         end else begin
            mode_in = sel_mode;
         end
      end
   end

   // Parse mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== sv/serial_command_led_pwm_dimmer_core.sv =====
// Top level of the serial command LED PWM dimmer.
// Depends on scpd_pkg and scpd_parser.
//
// Usage:
//   req channel: one word per item. req_tuser is the item kind (0 = PWM tick,
//   1 = received serial byte), req_tdata carries the byte.
//   rsp channel: one word per accepted item, in order. rsp_tdata holds the LED
//   pin levels (0 = lit) and the echoed byte, rsp_tuser flags a valid echo.
//   csr port: write-only, one register per cycle while csr_we is high, to be
//   used only while no item is in flight.
// Output: an accepted word is registered in the result register and read on rsp.
// Throughput: one item per cycle while req_tready is high; all work is a single
//   combinational pass from the state registers into the result register.
// Stall: a two-word output buffer (result register plus skid register)
//   keeps req_tready high while one result waits; req_tready falls only when
//   both entries are full, and rises again the cycle after rsp takes a word.
// Reset: synchronous; parser idle, all duties 3, counters 0, all pins lit,
//   registers at their defaults, output buffer empty.

module serial_command_led_pwm_dimmer_core #(
   parameter int CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] led_pins, [15:8] echo_byte
   output logic        rsp_tuser,   // [0] echo_valid
   // configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import scpd_pkg::*;

   localparam int SHOWN = (CHANNELS < 8) ? CHANNELS : 8;

   // Configuration registers
   logic [3:0]  period_ff;
   levels_type  levels_ff;

   // PWM state
   logic [3:0]  duty_ff  [CHANNELS];
   logic [3:0]  duty_in  [CHANNELS];
   logic [3:0]  count_ff [CHANNELS];
   logic [3:0]  count_in [CHANNELS];
   logic [7:0]  pins_ff, pins_in;
   logic [CHANNELS-1:0] dark;
   logic [4:0]  step_n   [CHANNELS];

   // Output buffer
   logic        out_v_ff, skid_v_ff;
   logic [16:0] out_ff, skid_ff;
   logic [16:0] result;

   logic        accept, take, is_byte, is_tick;
   duty_cmd_type duty_cmd;

   assign req_tready = !skid_v_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_v_ff && rsp_tready;
   assign is_byte    = accept && (req_tuser == FUNC_BYTE);
   assign is_tick    = accept && (req_tuser == FUNC_TICK);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= PERIOD_RESET;
         levels_ff.open  <= OPEN_RESET;
         levels_ff.close <= CLOSE_RESET;
         levels_ff.mid   <= MID_RESET;
         levels_ff.high  <= HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PERIOD_TICKS: period_ff       <= csr_wdata;
            REG_LEVEL_OPEN:   levels_ff.open  <= csr_wdata;
            REG_LEVEL_CLOSE:  levels_ff.close <= csr_wdata;
            REG_LEVEL_MID:    levels_ff.mid   <= csr_wdata;
            REG_LEVEL_HIGH:   levels_ff.high  <= csr_wdata;
            default: ;
         endcase
      end
   end

   scpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (is_byte),
      .rx_byte    (req_tdata),
      .levels     (levels_ff),
      .duty_cmd   (duty_cmd)
   );

   // Per-channel duty writes and PWM tick
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         step_n[i] = {1'b0, count_ff[i]} + 5'd1;
         dark[i]   = !((step_n[i] < {1'b0, duty_ff[i]}) || (duty_ff[i] > period_ff));
         count_in[i] = count_ff[i];
         if (is_tick) begin
            count_in[i] = (step_n[i] >= {1'b0, period_ff}) ? 4'd0 : step_n[i][3:0];
         end
         duty_in[i] = duty_ff[i];
         if (duty_cmd.all || (duty_cmd.one && ({29'd0, duty_cmd.ch} == 32'(i)))) begin
            duty_in[i] = duty_cmd.level;
         end
      end
      pins_in = is_tick ? 8'(dark[SHOWN-1:0]) : pins_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff <= 8'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            duty_ff[i]  <= DUTY_RESET;
            count_ff[i] <= 4'd0;
         end
      end else begin
         pins_ff <= pins_in;
         for (int i = 0; i < CHANNELS; i++) begin
            duty_ff[i]  <= duty_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // Result word: {echo_valid, echo_byte, led_pins}
   assign result = (req_tuser == FUNC_BYTE) ? {1'b1, req_tdata, pins_in}
                                            : {1'b0, 8'd0, pins_in};

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (take) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= accept;
            end
         end else if (accept) begin
            if (out_v_ff) begin
               skid_v_ff <= 1'b1;
            end else begin
               out_v_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_v_ff) begin
         out_ff <= skid_ff;
      end else if (accept && (take || !out_v_ff)) begin
         out_ff <= result;
      end
      if (accept && out_v_ff && !take) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff[15:0];
   assign rsp_tuser  = out_ff[16];

`ifndef ASSERT_OFF
   // Skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid without result entry");

   // A tick result never carries an echo byte
   a_tick_no_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[15:8] == 8'd0))
      else $error("tick result carries echo data");

   // Output buffer is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("output buffer not empty after reset");
`endif

endmodule

// ===== test/serial_command_led_pwm_dimmer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for serial_command_led_pwm_dimmer_core: directed and random
// byte/tick traffic against a cycle-free dimmer predictor. Depends on scpd_pkg.

module serial_command_led_pwm_dimmer_core_tb;
   import scpd_pkg::*;

   localparam int          CHANNELS       = 8;
   localparam int          STALL_LIMIT    = 3000;
   localparam int          BACKLOG_CYCLES = 250;
   localparam logic [2:0]  REG_LAST_INDEX = 3'd7;
   localparam logic [7:0]  CHAR_X         = "x";

   typedef enum logic [2:0] {
      PM_IDLE, PM_OPEN, PM_CLOSE, PM_ALT, PM_MID, PM_HIGH
   } cmd_mode_type;

   typedef struct packed {
      logic [7:0] pins;
      logic       echo_valid;
      logic [7:0] echo;
   } pwm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tuser = 1'b0;    // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] led_pins, [15:8] echo_byte
   logic        rsp_tuser;           // [0] echo_valid
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [3:0]  csr_wdata = 4'd0;

   // predictor state
   logic [3:0]  period_reg, open_reg, close_reg, mid_reg, high_reg;
   cmd_mode_type cmd_mode;
   logic [3:0]  duty_lvl [CHANNELS];
   logic [3:0]  pwm_cnt [CHANNELS];
   logic [7:0]  pin_state;
   pwm_result_type expected_words [$];

   int          mismatches = 0;
   int          idle_cycles = 0;
   int          words_sent = 0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   bit          rx_hold_request = 1'b0;
   bit          rx_holding = 1'b0;

   serial_command_led_pwm_dimmer_core #(.CHANNELS(CHANNELS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void clear_dimmer_state();
      period_reg = PERIOD_RESET;
      open_reg   = OPEN_RESET;
      close_reg  = CLOSE_RESET;
      mid_reg    = MID_RESET;
      high_reg   = HIGH_RESET;
      cmd_mode   = PM_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
         duty_lvl[i] = DUTY_RESET;
         pwm_cnt[i]  = 4'd0;
      end
      pin_state = 8'h00;
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [3:0] val);
      case (idx)
         REG_PERIOD_TICKS: period_reg = val;
         REG_LEVEL_OPEN:   open_reg   = val;
         REG_LEVEL_CLOSE:  close_reg  = val;
         REG_LEVEL_MID:    mid_reg    = val;
         REG_LEVEL_HIGH:   high_reg   = val;
         default: ;  // unmapped index, dropped
      endcase
   endfunction

   // command parser: letter picks a level, digit or N writes it
   function automatic void apply_serial_char(input logic [7:0] ch);
      logic [3:0] lvl;
      logic       all_ok;
      logic       is_digit;
      int         target;
      is_digit = (ch >= CHAR_ONE) && (ch <= CHAR_EIGHT);
      case (ch)
         CHAR_O_UP, CHAR_O_LO: cmd_mode = PM_OPEN;
         CHAR_S_UP, CHAR_S_LO: cmd_mode = PM_CLOSE;
         CHAR_A_UP, CHAR_A_LO: cmd_mode = PM_ALT;
         CHAR_B_UP, CHAR_B_LO: cmd_mode = PM_MID;
         CHAR_C_UP, CHAR_C_LO: cmd_mode = PM_HIGH;
         default: if (!is_digit && ch != CHAR_N) cmd_mode = PM_IDLE;
      endcase
      all_ok = 1'b0;
      lvl    = 4'd0;
      case (cmd_mode)
         PM_OPEN, PM_ALT: begin
            lvl    = open_reg;
            all_ok = 1'b1;
         end
         PM_CLOSE: begin
            lvl    = close_reg;
            all_ok = 1'b1;
         end
         PM_MID:  lvl = mid_reg;
         PM_HIGH: lvl = high_reg;
         default: return;
      endcase
      if (is_digit) begin
         target = int'(ch - CHAR_ONE);
         if (target < CHANNELS) duty_lvl[target] = lvl;
         cmd_mode = PM_IDLE;
      end else if (ch == CHAR_N && all_ok) begin
         for (int i = 0; i < CHANNELS; i++) duty_lvl[i] = lvl;
         cmd_mode = PM_IDLE;
      end
   endfunction

   // one PWM tick: lit while count+1 < duty, or always when duty exceeds period
   function automatic void advance_pwm_counters();
      logic [4:0] nxt;
      logic       lit;
      logic [7:0] pins;
      pins = 8'h00;
      for (int i = 0; i < CHANNELS; i++) begin
         nxt = {1'b0, pwm_cnt[i]} + 5'd1;
         lit = (nxt < {1'b0, duty_lvl[i]}) || (duty_lvl[i] > period_reg);
         if (!lit && i < 8) pins[i] = 1'b1;
         pwm_cnt[i] = (nxt >= {1'b0, period_reg}) ? 4'd0 : nxt[3:0];
      end
      pin_state = pins;
   endfunction

   // track register writes and accepted words, queue the expected result
   always @(posedge clock) begin : model_update
      pwm_result_type res;
      if (reset) begin
         clear_dimmer_state();
      end else begin
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_BYTE) begin
               apply_serial_char(req_tdata);
               res.echo_valid = 1'b1;
               res.echo       = req_tdata;
            end else begin
               advance_pwm_counters();
               res.echo_valid = 1'b0;
               res.echo       = 8'h00;
            end
            res.pins = pin_state;
            expected_words.push_back(res);
         end
      end
   end

   // ------------------------------------------------------------------ checker
   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      pwm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: word expected none actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            check_field("led_pins", want.pins, rsp_tdata[7:0]);
            check_field("echo_valid", {7'd0, want.echo_valid}, {7'd0, rsp_tuser});
            check_field("echo_byte", want.echo, rsp_tdata[15:8]);
         end
      end
   end

   // no word moving for too long means a hang
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
         $display("serial_command_led_pwm_dimmer_core regression: fail");
         $finish;
      end
   end

   // --------------------------------------------------------------- idling
   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
      return $urandom_range(0, 3);
   endfunction

   // result side: random stalls, or one long hold-off on request
   initial begin : rx_side
      int unsigned hold;
      forever begin
         if (rx_hold_request) begin
            hold       = BACKLOG_CYCLES;
            rx_holding = 1'b1;
         end else if (rx_steady) begin
            hold = 0;
         end else begin
            hold = idle_len();
         end
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         if (rx_holding) begin
            rx_holding      = 1'b0;
            rx_hold_request = 1'b0;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------- stimulus tasks
   // offer one word after an optional gap, return at the edge that takes it
   task automatic send_word(input logic kind, input logic [7:0] value);
      int unsigned gap;
      gap = tx_steady ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // stop offering and wait until every result is back, plus the pipe latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // all registers written while idle, plus one write to an unmapped index
   task automatic set_registers(input logic [3:0] period, input logic [3:0] open_lvl,
                                input logic [3:0] close_lvl, input logic [3:0] mid_lvl,
                                input logic [3:0] high_lvl);
      drain();
      write_reg(REG_PERIOD_TICKS, period);
      write_reg(REG_LEVEL_OPEN, open_lvl);
      write_reg(REG_LEVEL_CLOSE, close_lvl);
      write_reg(REG_LEVEL_MID, mid_lvl);
      write_reg(3'($urandom_range(REG_LEVEL_HIGH + 1, REG_LAST_INDEX)), 4'($urandom));
      write_reg(REG_LEVEL_HIGH, high_lvl);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_command_letter();
      case ($urandom_range(0, 9))
         0: return CHAR_O_UP;
         1: return CHAR_O_LO;
         2: return CHAR_S_UP;
         3: return CHAR_S_LO;
         4: return CHAR_A_UP;
         5: return CHAR_A_LO;
         6: return CHAR_B_UP;
         7: return CHAR_B_LO;
         8: return CHAR_C_UP;
         default: return CHAR_C_LO;
      endcase
   endfunction

   // a run of ticks, a well-formed command, a stray byte or a broken command
   task automatic send_sentence();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         repeat ($urandom_range(1, 8)) send_word(FUNC_TICK, 8'($urandom));
      end else if (pick < 80) begin
         send_word(FUNC_BYTE, pick_command_letter());
         if ($urandom_range(0, 9) < 7)
            send_word(FUNC_BYTE, CHAR_ONE + 8'($urandom_range(0, 7)));
         else
            send_word(FUNC_BYTE, CHAR_N);
      end else if (pick < 90) begin
         send_word(FUNC_BYTE, 8'($urandom));
      end else begin
         send_word(FUNC_BYTE, pick_command_letter());
         send_word(FUNC_BYTE, 8'($urandom));
      end
   endtask

   task automatic run_traffic(input int count);
      int start;
      start = words_sent;
      while (words_sent - start < count) begin
         if ($urandom_range(0, 29) == 0) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
         end
         send_sentence();
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // ------------------------------------------------------------------- tests
   // parser corner cases at reset register values
   task automatic test_parser_commands();
      send_word(FUNC_BYTE, CHAR_N);               // N while idle
      send_word(FUNC_BYTE, CHAR_ONE + 8'd4);      // digit while idle
      send_word(FUNC_BYTE, CHAR_O_UP);
      send_word(FUNC_BYTE, CHAR_ONE + 8'd2);
      send_word(FUNC_BYTE, CHAR_S_LO);
      send_word(FUNC_BYTE, CHAR_EIGHT);
      send_word(FUNC_BYTE, CHAR_A_UP);
      send_word(FUNC_BYTE, CHAR_N);
      send_word(FUNC_BYTE, CHAR_B_UP);
      send_word(FUNC_BYTE, CHAR_N);               // N after B keeps the mode
      send_word(FUNC_BYTE, CHAR_ONE + 8'd1);
      send_word(FUNC_BYTE, CHAR_C_LO);
      send_word(FUNC_BYTE, CHAR_ONE);
      send_word(FUNC_BYTE, CHAR_C_UP);
      send_word(FUNC_BYTE, CHAR_X);               // unknown char drops to idle
      send_word(FUNC_BYTE, CHAR_ONE + 8'd3);
      send_word(FUNC_BYTE, CHAR_B_LO);
      send_word(FUNC_BYTE, CHAR_A_LO);            // new letter replaces the old
      send_word(FUNC_BYTE, CHAR_ONE + 8'd6);
      send_word(FUNC_BYTE, 8'h00);
      send_word(FUNC_BYTE, 8'hFF);
      repeat (4) send_word(FUNC_TICK, 8'hFF);
      send_word(FUNC_TICK, 8'h00);
   endtask

   // period of zero and one, duty above period, duty of zero
   task automatic test_period_edges();
      set_registers(4'd0, 4'd15, 4'd0, 4'd15, 4'd0);
      repeat (3) send_word(FUNC_TICK, 8'($urandom));
      send_word(FUNC_BYTE, CHAR_O_UP);
      send_word(FUNC_BYTE, CHAR_N);
      send_word(FUNC_TICK, 8'($urandom));
      set_registers(4'd1, 4'd1, 4'd0, 4'd2, 4'd15);
      send_word(FUNC_BYTE, CHAR_S_UP);
      send_word(FUNC_BYTE, CHAR_ONE);
      send_word(FUNC_BYTE, CHAR_B_UP);
      send_word(FUNC_BYTE, CHAR_ONE + 8'd1);
      send_word(FUNC_BYTE, CHAR_A_UP);
      send_word(FUNC_BYTE, CHAR_ONE + 8'd2);
      send_word(FUNC_BYTE, CHAR_C_UP);
      send_word(FUNC_BYTE, CHAR_ONE + 8'd3);
      repeat (3) send_word(FUNC_TICK, 8'($urandom));
   endtask

   // hold the result side off long enough that the input stalls
   task automatic test_output_backpressure();
      int start;
      drain();
      rx_hold_request = 1'b1;
      wait (rx_holding);
      @(posedge clock);
      tx_steady = 1'b1;
      start = words_sent;
      while (words_sent - start < 24) send_sentence();
      tx_steady = 1'b0;
      drain();
   endtask

   // random traffic over several register settings, extremes included
   task automatic test_random_traffic();
      set_registers(PERIOD_RESET, OPEN_RESET, CLOSE_RESET, MID_RESET, HIGH_RESET);
      run_traffic(190);
      set_registers(4'd15, 4'd15, 4'd0, 4'd15, 4'd0);
      run_traffic(190);
      set_registers(4'd2, 4'd0, 4'd15, 4'd0, 4'd15);
      run_traffic(190);
      repeat (3) begin
         set_registers(4'($urandom_range(2, 15)), 4'($urandom), 4'($urandom),
                       4'($urandom), 4'($urandom));
         run_traffic(190);
      end
      set_registers(4'($urandom_range(0, 1)), 4'($urandom), 4'($urandom),
                    4'($urandom), 4'($urandom));
      run_traffic(100);
   endtask

   initial begin : main
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_parser_commands();
      test_period_edges();
      test_output_backpressure();
      test_random_traffic();
      drain();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("serial_command_led_pwm_dimmer_core regression: pass");
      else
         $display("serial_command_led_pwm_dimmer_core regression: fail");
      $finish;
   end

endmodule
